// ===== design/gstp_pkg.sv =====
// Shared types and constants for the one-dimensional global search trial planner.
// Holds the request and result words, register indexes and reset defaults.
// No dependencies.
package gstp_pkg;

    // Default sizing of the trial store and the stored value width.
    localparam int DEF_MAX_TRIALS  = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // Width of the operands of the shared serial divider.
    localparam int DIV_W = 64;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXT  = 3'd4;

    // Register reset values.
    localparam logic [31:0] RST_LOWER = 32'd0;
    localparam logic [31:0] RST_UPPER = 32'd65536;
    localparam logic [30:0] RST_EPS   = 31'd1;
    localparam logic [30:0] RST_REL   = 31'd262144;
    localparam logic [10:0] RST_MAXT  = 11'd1024;

    // Request kinds.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VALUE = 1'b1;

    // Stop reasons.
    localparam logic [1:0] STOP_NONE  = 2'd0;
    localparam logic [1:0] STOP_CONV  = 2'd1;
    localparam logic [1:0] STOP_LIMIT = 2'd2;

    // Request word.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] trial_value;
    } t_req;

    // Result word.
    typedef struct packed {
        logic signed [31:0] next_point;
        logic               need_value;
        logic               done_res;
        logic [1:0]         stop_reason;
        logic signed [31:0] best_point;
        logic signed [31:0] best_value;
        logic [10:0]        trial_count;
    } t_res;

endpackage

// ===== design/global_search_trial_planner_core.sv =====
// Top level of the one-dimensional global search trial planner: sequencer, registers, store.
// Depends on gstp_pkg, gstp_mem and gstp_div.
//
//  channel    | ports                                   | handshake
//  -----------+-----------------------------------------+---------------------------
//  request    | start, busy, i_req                      | taken when start & !busy
//  result     | o_res_valid, o_res                      | one-cycle strobe, no stall
//  config     | i_cfg_valid, o_cfg_ready, i_cfg_index,  | written when valid & ready
//             | i_cfg_data                              | (ready is always high)
//
// A start request, the first bound value, or a value while idle or done goes from ST_IDLE
// straight to ST_OUT, which registers its result word. The second bound value and a value
// during the search first write or insert the point into the sorted store, moving larger
// entries up one place at a time, then, unless the search stops, plan the next point in two
// sweeps over the n stored entries: the first finds the slope bound and the second the
// characteristic of each interval, both by way of the serial divider.
// Reset is synchronous; it clears control state. The store is never cleared, as every
// entry is written before it is read. The result receiver cannot stall the block.
module global_search_trial_planner_core import gstp_pkg::*; #(
    parameter int MAX_TRIALS  = DEF_MAX_TRIALS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_res_valid,
    output t_res                 o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int DEPTH = MAX_TRIALS + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam logic signed [32:0] VAL_HI  = (33'sd1 <<< (VW - 1)) - 33'sd1;
    localparam logic signed [32:0] VAL_LO  = -VAL_HI - 33'sd1;
    localparam logic [10:0]        EFF_CAP = (MAX_TRIALS > 2047) ? 11'd2047 : 11'(MAX_TRIALS);
    localparam logic [64:0]        RMU_MAX = 65'd1 << 62;
    localparam logic [63:0]        Q1_MAX  = 64'hFFFF_FFFF;
    localparam logic [63:0]        T2_MAX  = 64'd1 << 40;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BOUNDS,
        PH_RUN,
        PH_DONE
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE, ST_WB0, ST_WB1, ST_INS, ST_INSC, ST_INSW, ST_CHK, ST_PLAN,
        ST_P0, ST_PL, ST_PD, ST_MUW, ST_Q1W, ST_SQ, ST_T2, ST_T2W, ST_T3W,
        ST_RV, ST_NX, ST_RMU0, ST_RMU1, ST_FIN, ST_FINW, ST_OUT
    } t_state;

    // Configuration registers.
    logic signed [31:0] r_lb;
    logic signed [31:0] r_ub;
    logic [30:0]        r_eps;
    logic [30:0]        r_rel;
    logic [10:0]        r_maxt;

    // Search state.
    t_state             r_st;
    t_phase             r_phase;
    logic [CW-1:0]      r_count;
    logic [10:0]        r_new;
    logic signed [31:0] r_pend;
    logic signed [31:0] r_best_pos;
    logic signed [31:0] r_best_val;
    logic [1:0]         r_stop;
    logic signed [31:0] r_pend_left;
    logic signed [31:0] r_pend_right;
    logic signed [31:0] r_lb_lat;
    logic signed [31:0] r_ub_lat;
    logic signed [31:0] r_first_val;
    logic               r_need;
    logic               r_res_valid;
    t_res               r_res;

    // Working registers of one step.
    logic signed [31:0] r_val;
    logic [CW-1:0]      r_pos;
    logic [CW-1:0]      r_i;
    logic               r_pass_char;
    logic signed [31:0] r_prev_p;
    logic signed [31:0] r_prev_v;
    logic signed [31:0] r_cur_p;
    logic signed [31:0] r_cur_v;
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic signed [33:0] r_s2;
    logic [48:0]        r_mu;
    logic [63:0]        r_ph;
    logic [46:0]        r_pl;
    logic [62:0]        r_rmu;
    logic [31:0]        r_q1;
    logic [63:0]        r_sq;
    logic [40:0]        r_t2;
    logic signed [50:0] r_t3;
    logic               r_have;
    logic signed [52:0] r_best_r;
    logic signed [31:0] r_t_pl;
    logic signed [31:0] r_t_pr;
    logic signed [31:0] r_t_vl;
    logic signed [31:0] r_t_vr;

    // Store and divider connections.
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [31:0]   mem_wpoint;
    logic signed [31:0]   mem_wval;
    logic [AW-1:0]        mem_raddr;
    logic signed [31:0]   rd_p;
    logic signed [VW-1:0] mem_rvalue;
    logic signed [31:0]   rd_v;
    logic                 div_start;
    logic [DIV_W-1:0]     div_num;
    logic [DIV_W-1:0]     div_den;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;

    // Derived values.
    logic signed [32:0] in_wide;
    logic signed [31:0] in_val;
    logic [10:0]        eff;
    logic               swap;
    logic [CW-1:0]      pos_m1;
    logic [CW-1:0]      pos_m2;
    logic [CW-1:0]      i_p1;
    logic [32:0]        dy_mag;
    logic [33:0]        s2_mag;
    logic signed [32:0] pl_dx;
    logic signed [32:0] pl_dy;
    logic signed [32:0] pl_sum;
    logic signed [32:0] near_dr;
    logic signed [32:0] near_dl;
    logic [32:0]        near_rm;
    logic [32:0]        near_lm;
    logic               near;
    logic               improves;
    logic [48:0]        mu_eff;
    logic [64:0]        rmu_sum;
    logic signed [52:0] rv;
    logic signed [32:0] dxt;
    logic signed [32:0] dyt;
    logic [32:0]        dyt_mag;
    logic signed [33:0] half_dx;
    logic signed [50:0] fin_q;
    logic signed [50:0] new_p;
    logic signed [31:0] new_sat;

    gstp_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .VW    (VW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wpoint (mem_wpoint),
        .i_wvalue (mem_wval[VW-1:0]),
        .i_raddr  (mem_raddr),
        .o_rpoint (rd_p),
        .o_rvalue (mem_rvalue)
    );

    gstp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Input value saturated to the stored value width, and stored values widened back.
    always_comb begin
        in_wide = {i_req.trial_value[31], i_req.trial_value};
        if (in_wide > VAL_HI) begin
            in_val = VAL_HI[31:0];
        end else if (in_wide < VAL_LO) begin
            in_val = VAL_LO[31:0];
        end else begin
            in_val = i_req.trial_value;
        end
        rd_v = 32'(mem_rvalue);
    end

    // Small helpers shared by several states.
    always_comb begin
        eff      = (r_maxt > EFF_CAP) ? EFF_CAP : r_maxt;
        swap     = (r_ub_lat < r_lb_lat);
        pos_m1   = r_pos - 1'b1;
        pos_m2   = r_pos - CW'(2);
        i_p1     = r_i + 1'b1;
        dy_mag   = r_dy[32] ? (33'd0 - r_dy) : r_dy;
        s2_mag   = r_s2[33] ? (34'd0 - r_s2) : r_s2;
        pl_dx    = {rd_p[31], rd_p} - {r_prev_p[31], r_prev_p};
        pl_dy    = {rd_v[31], rd_v} - {r_prev_v[31], r_prev_v};
        pl_sum   = {rd_v[31], rd_v} + {r_prev_v[31], r_prev_v};
        near_dr  = {r_pend_right[31], r_pend_right} - {r_pend[31], r_pend};
        near_dl  = {r_pend_left[31], r_pend_left} - {r_pend[31], r_pend};
        near_rm  = near_dr[32] ? (33'd0 - near_dr) : near_dr;
        near_lm  = near_dl[32] ? (33'd0 - near_dl) : near_dl;
        near     = (near_rm < {2'b00, r_eps}) || (near_lm < {2'b00, r_eps});
        improves = (r_val < r_best_val);
        mu_eff   = (r_mu == '0) ? 49'd65536 : r_mu;
        rmu_sum  = {1'b0, r_ph} + 65'(r_pl[46:16]);
        rv       = {{20{r_dx[32]}}, r_dx} + {12'b0, r_t2} - {{2{r_t3[50]}}, r_t3};
    end

    // Placement of the new point in the chosen interval.
    always_comb begin
        dxt     = {r_t_pr[31], r_t_pr} - {r_t_pl[31], r_t_pl};
        dyt     = {r_t_vr[31], r_t_vr} - {r_t_vl[31], r_t_vl};
        dyt_mag = dyt[32] ? (33'd0 - dyt) : dyt;
        half_dx = ({dxt[32], dxt} + {33'b0, dxt[32]}) >>> 1;
        fin_q   = dyt[32] ? (51'sd0 - {1'b0, div_quo[49:0]}) : {1'b0, div_quo[49:0]};
        new_p   = {{19{r_t_pl[31]}}, r_t_pl} + {{17{half_dx[33]}}, half_dx} - fin_q;
        if (new_p > 51'sd2147483647) begin
            new_sat = 32'sh7FFF_FFFF;
        end else if (new_p < -51'sd2147483648) begin
            new_sat = 32'sh8000_0000;
        end else begin
            new_sat = new_p[31:0];
        end
    end

    // Store accesses and divider requests issued by each state.
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wpoint = r_pend;
        mem_wval   = r_val;
        mem_raddr  = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = 64'd1;
        unique case (r_st)
            ST_WB0: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wpoint = swap ? r_ub_lat : r_lb_lat;
                mem_wval   = swap ? r_val : r_first_val;
            end
            ST_WB1: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(1);
                mem_wpoint = swap ? r_lb_lat : r_ub_lat;
                mem_wval   = swap ? r_first_val : r_val;
            end
            ST_INS: begin
                mem_raddr = pos_m1[AW-1:0];
            end
            ST_INSC: begin
                if (rd_p > r_pend) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_pos[AW-1:0];
                    mem_wpoint = rd_p;
                    mem_wval   = rd_v;
                    mem_raddr  = pos_m2[AW-1:0];
                end
            end
            ST_INSW: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
            end
            ST_P0: begin
                mem_raddr = AW'(1);
            end
            ST_NX: begin
                mem_raddr = i_p1[AW-1:0];
            end
            ST_PD: begin
                if (r_dx > 33'sd0) begin
                    div_start = 1'b1;
                    div_num   = 64'({dy_mag, 16'b0});
                    div_den   = r_pass_char ? 64'(r_rmu) : 64'(r_dx[31:0]);
                end
            end
            ST_T2: begin
                div_start = 1'b1;
                div_num   = r_sq;
                div_den   = 64'(r_dx[31:0]);
            end
            ST_T2W: begin
                div_start = div_done;
                div_num   = 64'({s2_mag, 16'b0});
                div_den   = 64'(r_rmu);
            end
            ST_FIN: begin
                div_start = 1'b1;
                div_num   = 64'({dyt_mag, 16'b0});
                div_den   = {r_rmu, 1'b0};
            end
            default: begin
            end
        endcase
    end

    // Configuration registers; writes must come only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lb   <= RST_LOWER;
            r_ub   <= RST_UPPER;
            r_eps  <= RST_EPS;
            r_rel  <= RST_REL;
            r_maxt <= RST_MAXT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOWER: r_lb   <= i_cfg_data;
                CFG_UPPER: r_ub   <= i_cfg_data;
                CFG_EPS:   r_eps  <= i_cfg_data[30:0];
                CFG_REL:   r_rel  <= i_cfg_data[30:0];
                CFG_MAXT:  r_maxt <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: takes a word, runs the step and registers its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= ST_IDLE;
            r_phase      <= PH_IDLE;
            r_count      <= '0;
            r_new        <= '0;
            r_pend       <= '0;
            r_best_pos   <= '0;
            r_best_val   <= '0;
            r_stop       <= STOP_NONE;
            r_pend_left  <= '0;
            r_pend_right <= '0;
            r_need       <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (start) begin
                        r_val <= in_val;
                        if (i_req.req_type == REQ_START) begin
                            r_count    <= '0;
                            r_new      <= '0;
                            r_best_pos <= '0;
                            r_best_val <= '0;
                            r_stop     <= STOP_NONE;
                            r_lb_lat   <= r_lb;
                            r_ub_lat   <= r_ub;
                            r_pend     <= r_lb;
                            r_phase    <= PH_BOUNDS;
                            r_need     <= 1'b1;
                            r_st       <= ST_OUT;
                        end else if (r_phase == PH_BOUNDS && r_count == '0) begin
                            r_first_val <= in_val;
                            r_count     <= CW'(1);
                            r_pend      <= r_ub_lat;
                            r_need      <= 1'b1;
                            r_st        <= ST_OUT;
                        end else if (r_phase == PH_BOUNDS) begin
                            r_count <= CW'(2);
                            if (r_first_val < in_val) begin
                                r_best_pos <= r_lb_lat;
                                r_best_val <= r_first_val;
                            end else begin
                                r_best_pos <= r_ub_lat;
                                r_best_val <= in_val;
                            end
                            if (eff == '0) begin
                                r_phase <= PH_DONE;
                                r_stop  <= STOP_LIMIT;
                                r_need  <= 1'b0;
                                r_st    <= ST_OUT;
                            end else begin
                                r_st <= ST_WB0;
                            end
                        end else if (r_phase == PH_RUN) begin
                            r_new <= r_new + 1'b1;
                            r_pos <= r_count;
                            r_st  <= (r_count < CW'(DEPTH)) ? ST_INS : ST_CHK;
                        end else begin
                            r_need <= 1'b0;
                            r_st   <= ST_OUT;
                        end
                    end
                end
                ST_WB0: begin
                    r_st <= ST_WB1;
                end
                ST_WB1: begin
                    r_phase <= PH_RUN;
                    r_st    <= ST_PLAN;
                end
                // Insertion: move larger entries up one place until the slot is found.
                ST_INS: begin
                    r_st <= (r_pos == '0) ? ST_INSW : ST_INSC;
                end
                ST_INSC: begin
                    if (rd_p > r_pend) begin
                        r_pos <= pos_m1;
                        if (r_pos == CW'(1)) begin
                            r_st <= ST_INSW;
                        end
                    end else begin
                        r_st <= ST_INSW;
                    end
                end
                ST_INSW: begin
                    r_count <= r_count + 1'b1;
                    r_st    <= ST_CHK;
                end
                // Best tracking and the two stopping rules.
                ST_CHK: begin
                    if (improves) begin
                        r_best_pos <= r_pend;
                        r_best_val <= r_val;
                    end
                    if (improves && near) begin
                        r_phase <= PH_DONE;
                        r_stop  <= STOP_CONV;
                        r_need  <= 1'b0;
                        r_st    <= ST_OUT;
                    end else if (r_new >= eff) begin
                        r_phase <= PH_DONE;
                        r_stop  <= STOP_LIMIT;
                        r_need  <= 1'b0;
                        r_st    <= ST_OUT;
                    end else begin
                        r_st <= ST_PLAN;
                    end
                end
                // Planning: first sweep finds the slope bound, second the best interval.
                ST_PLAN: begin
                    r_pass_char <= 1'b0;
                    r_mu        <= '0;
                    r_st        <= ST_P0;
                end
                ST_P0: begin
                    r_prev_p <= rd_p;
                    r_prev_v <= rd_v;
                    r_i      <= CW'(1);
                    r_st     <= ST_PL;
                end
                ST_PL: begin
                    r_cur_p <= rd_p;
                    r_cur_v <= rd_v;
                    r_dx    <= pl_dx;
                    r_dy    <= pl_dy;
                    r_s2    <= {pl_sum, 1'b0};
                    r_st    <= ST_PD;
                end
                ST_PD: begin
                    if (r_pass_char && r_i == CW'(1)) begin
                        r_t_pl <= r_prev_p;
                        r_t_pr <= r_cur_p;
                        r_t_vl <= r_prev_v;
                        r_t_vr <= r_cur_v;
                    end
                    if (r_dx > 33'sd0) begin
                        r_st <= r_pass_char ? ST_Q1W : ST_MUW;
                    end else begin
                        r_st <= ST_NX;
                    end
                end
                ST_MUW: begin
                    if (div_done) begin
                        if (div_quo[48:0] > r_mu) begin
                            r_mu <= div_quo[48:0];
                        end
                        r_st <= ST_NX;
                    end
                end
                ST_Q1W: begin
                    if (div_done) begin
                        r_q1 <= (div_quo > Q1_MAX) ? Q1_MAX[31:0] : div_quo[31:0];
                        r_st <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sq <= r_q1 * r_q1;
                    r_st <= ST_T2;
                end
                ST_T2: begin
                    r_st <= ST_T2W;
                end
                ST_T2W: begin
                    if (div_done) begin
                        r_t2 <= (div_quo > T2_MAX) ? T2_MAX[40:0] : div_quo[40:0];
                        r_st <= ST_T3W;
                    end
                end
                ST_T3W: begin
                    if (div_done) begin
                        r_t3 <= r_s2[33] ? (51'sd0 - {1'b0, div_quo[49:0]})
                                         : {1'b0, div_quo[49:0]};
                        r_st <= ST_RV;
                    end
                end
                ST_RV: begin
                    if (!r_have || rv > r_best_r) begin
                        r_have   <= 1'b1;
                        r_best_r <= rv;
                        r_t_pl   <= r_prev_p;
                        r_t_pr   <= r_cur_p;
                        r_t_vl   <= r_prev_v;
                        r_t_vr   <= r_cur_v;
                    end
                    r_st <= ST_NX;
                end
                ST_NX: begin
                    r_prev_p <= r_cur_p;
                    r_prev_v <= r_cur_v;
                    r_i      <= i_p1;
                    if (i_p1 < r_count) begin
                        r_st <= ST_PL;
                    end else begin
                        r_st <= r_pass_char ? ST_FIN : ST_RMU0;
                    end
                end
                // Scaled slope bound r*mu, saturated and never zero.
                ST_RMU0: begin
                    r_ph <= r_rel * mu_eff[48:16];
                    r_pl <= r_rel * mu_eff[15:0];
                    r_st <= ST_RMU1;
                end
                ST_RMU1: begin
                    if (rmu_sum > RMU_MAX) begin
                        r_rmu <= RMU_MAX[62:0];
                    end else if (rmu_sum == '0) begin
                        r_rmu <= 63'd1;
                    end else begin
                        r_rmu <= rmu_sum[62:0];
                    end
                    r_pass_char <= 1'b1;
                    r_have      <= 1'b0;
                    r_st        <= ST_P0;
                end
                ST_FIN: begin
                    r_st <= ST_FINW;
                end
                ST_FINW: begin
                    if (div_done) begin
                        r_pend       <= new_sat;
                        r_pend_left  <= r_t_pl;
                        r_pend_right <= r_t_pr;
                        r_need       <= 1'b1;
                        r_st         <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_res_valid       <= 1'b1;
                    r_res.next_point  <= r_need ? r_pend : 32'sd0;
                    r_res.need_value  <= r_need;
                    r_res.done_res    <= (r_phase == PH_DONE);
                    r_res.stop_reason <= r_stop;
                    r_res.best_point  <= r_best_pos;
                    r_res.best_value  <= r_best_val;
                    r_res.trial_count <= r_new;
                    r_st              <= ST_IDLE;
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_st != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== design/gstp_div.sv =====
// Radix-2 restoring divider for unsigned DIV_W-bit operands, one quotient bit per cycle.
// Depends on gstp_pkg for DIV_W.
module gstp_div import gstp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             fits;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        shifted = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
    end

    // Control: count the quotient bits and flag completion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // Datapath: the dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= fits ? diff : shifted;
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end else if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== design/gstp_mem.sv =====
// Trial store: one point and one value per entry, one write and one registered read per cycle.
// Depends on gstp_pkg for the default sizing of its parameters.
module gstp_mem import gstp_pkg::*; #(
    parameter int DEPTH = DEF_MAX_TRIALS + 2,
    parameter int AW    = $clog2(DEF_MAX_TRIALS + 2),
    parameter int VW    = DEF_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [31:0]   i_wpoint,
    input  logic signed [VW-1:0] i_wvalue,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [31:0]   o_rpoint,
    output logic signed [VW-1:0] o_rvalue
);

    logic signed [31:0]   r_points [DEPTH];
    logic signed [VW-1:0] r_values [DEPTH];
    logic signed [31:0]   r_rd_point;
    logic signed [VW-1:0] r_rd_value;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_points[i_waddr] <= i_wpoint;
            r_values[i_waddr] <= i_wvalue;
        end
        r_rd_point <= r_points[i_raddr];
        r_rd_value <= r_values[i_raddr];
    end

    assign o_rpoint = r_rd_point;
    assign o_rvalue = r_rd_value;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for global_search_trial_planner_core.
// Depends on gstp_pkg; drives searches with objective values and checks each result word
// against a bit-exact predictor of the planner kept in this file.
module testbench import gstp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = DEF_MAX_TRIALS + 2;
    localparam longint unsigned RMU_CAP = 64'd1 << 62;
    localparam longint unsigned CHAR_CAP = 64'd1 << 40;

    typedef enum logic [1:0] {PH_IDLE, PH_BOUNDS, PH_RUN, PH_DONE} t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_res_valid;
    t_res o_res;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LOWER;
    logic [31:0] i_cfg_data = '0;

    global_search_trial_planner_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_valid(o_res_valid), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predictor copy of the registers and the search state.
    logic signed [31:0] lo_reg = RST_LOWER, up_reg = RST_UPPER;
    logic [30:0] eps_reg = RST_EPS, rel_reg = RST_REL;
    logic [10:0] maxt_reg = RST_MAXT;
    int pts [STORE_DEPTH];
    int vals [STORE_DEPTH];
    int unsigned n_stored = 0;
    t_phase ph = PH_IDLE;
    int pend_pt = 0, best_pos = 0, best_val = 0, pend_lo = 0, pend_hi = 0;
    int unsigned n_new = 0;
    logic [1:0] stop_code = STOP_NONE;

    t_res expected_words [$];
    int errors = 0, n_items = 0, n_words = 0, n_searches = 0, n_conv = 0, n_limit = 0;
    int gap_pct = 0;
    int obj_mode = 0;
    longint obj_center = 0;

    function automatic longint unsigned umag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Q16.16 quotient truncated toward zero.
    function automatic longint q16_div(longint num, longint unsigned den);
        longint unsigned q;
        q = (umag(num) << 16) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int unsigned trial_cap();
        return maxt_reg > DEF_MAX_TRIALS ? DEF_MAX_TRIALS : maxt_reg;
    endfunction

    // Scaled Lipschitz estimate r*mu from the steepest neighboring slope.
    function automatic longint unsigned scaled_mu();
        longint unsigned mu, r, bh, bl, rmu, s;
        longint dx;
        mu = 0;
        r = rel_reg;
        for (int i = 1; i < n_stored; i++) begin
            dx = longint'(pts[i]) - pts[i-1];
            if (dx > 0) begin
                s = (umag(longint'(vals[i]) - vals[i-1]) << 16) / dx;
                if (s > mu) mu = s;
            end
        end
        if (mu == 0) mu = 65536;
        bh = mu >> 16;
        bl = mu & 64'hFFFF;
        if (r != 0 && bh > RMU_CAP / r) begin
            rmu = RMU_CAP;
        end else begin
            rmu = r * bh + ((r * bl) >> 16);
            if (rmu > RMU_CAP) rmu = RMU_CAP;
        end
        return rmu == 0 ? 1 : rmu;
    endfunction

    // Picks the first interval with the greatest characteristic and places the next point.
    function automatic void plan_point();
        longint unsigned rmu, q1, t2;
        longint dx, dy, t3, rv, best_r, mid;
        int unsigned pick;
        bit have;
        rmu = scaled_mu();
        pick = 1;
        have = 0;
        best_r = 0;
        for (int i = 1; i < n_stored; i++) begin
            dx = longint'(pts[i]) - pts[i-1];
            dy = longint'(vals[i]) - vals[i-1];
            if (dx > 0) begin
                q1 = (umag(dy) << 16) / rmu;
                if (q1 > 64'hFFFFFFFF) q1 = 64'hFFFFFFFF;
                t2 = (q1 * q1) / dx;
                if (t2 > CHAR_CAP) t2 = CHAR_CAP;
                t3 = q16_div(2 * (longint'(vals[i]) + vals[i-1]), rmu);
                rv = dx + longint'(t2) - t3;
                if (!have || rv > best_r) begin
                    have = 1;
                    best_r = rv;
                    pick = i;
                end
            end
        end
        dx = longint'(pts[pick]) - pts[pick-1];
        dy = longint'(vals[pick]) - vals[pick-1];
        mid = longint'(pts[pick-1]) + dx / 2;
        pend_pt = sat32(mid - q16_div(dy, 2 * rmu));
        pend_lo = pts[pick-1];
        pend_hi = pts[pick];
    endfunction

    // Advances the predicted planner by one request word and returns the result word.
    function automatic t_res search_step(t_req rq);
        t_res r;
        bit need;
        int v, x, tp, tv;
        int unsigned pos;
        need = 0;
        v = rq.trial_value;
        if (rq.req_type == REQ_START) begin
            n_stored = 0;
            n_new = 0;
            best_pos = 0;
            best_val = 0;
            stop_code = STOP_NONE;
            pts[0] = lo_reg;
            pts[1] = up_reg;
            pend_pt = pts[0];
            ph = PH_BOUNDS;
            need = 1;
        end else if (ph == PH_BOUNDS) begin
            vals[n_stored & 1] = v;
            n_stored++;
            if (n_stored == 1) begin
                pend_pt = pts[1];
                need = 1;
            end else begin
                if (vals[0] < vals[1]) begin
                    best_pos = pts[0];
                    best_val = vals[0];
                end else begin
                    best_pos = pts[1];
                    best_val = vals[1];
                end
                if (pts[1] < pts[0]) begin
                    tp = pts[0];
                    tv = vals[0];
                    pts[0] = pts[1];
                    vals[0] = vals[1];
                    pts[1] = tp;
                    vals[1] = tv;
                end
                if (trial_cap() == 0) begin
                    ph = PH_DONE;
                    stop_code = STOP_LIMIT;
                end else begin
                    plan_point();
                    ph = PH_RUN;
                    need = 1;
                end
            end
        end else if (ph == PH_RUN) begin
            x = pend_pt;
            if (n_stored < STORE_DEPTH) begin
                pos = n_stored;
                while (pos > 0 && pts[pos-1] > x) begin
                    pts[pos] = pts[pos-1];
                    vals[pos] = vals[pos-1];
                    pos--;
                end
                pts[pos] = x;
                vals[pos] = v;
                n_stored++;
            end
            n_new++;
            if (v < best_val) begin
                best_pos = x;
                best_val = v;
                if (umag(longint'(pend_hi) - x) < eps_reg ||
                    umag(longint'(pend_lo) - x) < eps_reg) begin
                    ph = PH_DONE;
                    stop_code = STOP_CONV;
                end
            end
            if (ph == PH_RUN) begin
                if (n_new >= trial_cap()) begin
                    ph = PH_DONE;
                    stop_code = STOP_LIMIT;
                end else begin
                    plan_point();
                    need = 1;
                end
            end
        end
        r.next_point = need ? pend_pt : 0;
        r.need_value = need;
        r.done_res = (ph == PH_DONE);
        r.stop_reason = stop_code;
        r.best_point = best_pos;
        r.best_value = best_val;
        r.trial_count = n_new[10:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Result checker: every strobed word is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            n_words++;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected", $realtime);
            end else begin
                want = expected_words.pop_front();
                if (o_res.next_point !== want.next_point)
                    report_mismatch("next_point", o_res.next_point, want.next_point);
                if (o_res.need_value !== want.need_value)
                    report_mismatch("need_value", o_res.need_value, want.need_value);
                if (o_res.done_res !== want.done_res)
                    report_mismatch("done_res", o_res.done_res, want.done_res);
                if (o_res.stop_reason !== want.stop_reason)
                    report_mismatch("stop_reason", o_res.stop_reason, want.stop_reason);
                if (o_res.best_point !== want.best_point)
                    report_mismatch("best_point", o_res.best_point, want.best_point);
                if (o_res.best_value !== want.best_value)
                    report_mismatch("best_value", o_res.best_value, want.best_value);
                if (o_res.trial_count !== want.trial_count)
                    report_mismatch("trial_count", o_res.trial_count, want.trial_count);
            end
        end
    end

    // Sends one request word, holding start until the planner takes it.
    task automatic send_word(logic kind, int value);
        t_phase was;
        while ($urandom_range(99) < gap_pct) @(negedge i_clk);
        start = 1'b1;
        i_req.req_type = kind;
        i_req.trial_value = value;
        do @(posedge i_clk); while (busy);
        was = ph;
        expected_words.push_back(search_step(i_req));
        n_items++;
        if (kind == REQ_START) n_searches++;
        if (was == PH_RUN && ph == PH_DONE) begin
            if (stop_code == STOP_CONV) n_conv++;
            else n_limit++;
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Waits until every expected word has come and the planner has settled.
    task automatic drain();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LOWER: lo_reg = data;
            CFG_UPPER: up_reg = data;
            CFG_EPS:   eps_reg = data[30:0];
            CFG_REL:   rel_reg = data[30:0];
            CFG_MAXT:  maxt_reg = data[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_search(int lo, int up, int eps, int rel, int maxt);
        drain();
        cfg_write(CFG_LOWER, lo);
        cfg_write(CFG_UPPER, up);
        cfg_write(CFG_EPS, eps);
        cfg_write(CFG_REL, rel);
        cfg_write(CFG_MAXT, maxt);
    endtask

    // Objective value at a requested point for the current test function.
    function automatic int probe_value(int x);
        longint d;
        d = (longint'(x) - obj_center) >>> 10;
        case (obj_mode)
            0: return $urandom;
            1: return sat32(((d * d) >>> 6) - 40000);
            2: return int'(obj_center);
            default: return sat32(umag(longint'(x) - obj_center) - 70000);
        endcase
    endfunction

    // Directed corner cases: idle values, flat objective, zero limit, odd bounds.
    task automatic test_directed();
        send_word(REQ_VALUE, 32'sh7FFFFFFF);
        send_word(REQ_START, 0);
        send_word(REQ_VALUE, 0);
        send_word(REQ_VALUE, 0);
        send_word(REQ_VALUE, 0);
        send_word(REQ_START, 0);
        send_word(REQ_VALUE, 5);
        send_word(REQ_VALUE, -5);
        send_word(REQ_VALUE, 100);
        set_search(100000, -100000, 1, 32'h7FFFFFFF, 0);
        send_word(REQ_START, 0);
        send_word(REQ_VALUE, 7);
        send_word(REQ_VALUE, 7);
        send_word(REQ_VALUE, 3);
        set_search(12345, 12345, 32'h7FFFFFFF, 65537, 3);
        send_word(REQ_START, 0);
        send_word(REQ_VALUE, 10);
        send_word(REQ_VALUE, 20);
        send_word(REQ_VALUE, 30);
        set_search(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 262144, 2047);
        send_word(REQ_START, 0);
        send_word(REQ_VALUE, 32'sh80000000);
        send_word(REQ_VALUE, 32'sh7FFFFFFF);
        send_word(REQ_VALUE, 32'sh80000000);
        send_word(REQ_VALUE, 32'sh80000000);
    endtask

    // Random searches: well-formed runs with some stray values and restarts.
    task automatic test_random(int n_words_goal, int idle_pct, bit hold_off);
        int lo, up, span, first, eps, rel;
        gap_pct = idle_pct;
        first = n_items;
        while (n_items - first < n_words_goal) begin
            if ($urandom_range(9) < 7) begin
                lo = int'($urandom_range(200000)) - 100000;
                span = $urandom_range(3) == 0 ? 0 : int'($urandom_range(400000));
                up = $urandom_range(4) == 0 ? lo - span : lo + span;
            end else begin
                lo = $urandom;
                up = $urandom;
            end
            case ($urandom_range(3))
                0: eps = 0;
                1: eps = 32'h7FFFFFFF;
                2: eps = $urandom_range(20000);
                default: eps = $urandom & 32'h7FFFFFFF;
            endcase
            case ($urandom_range(3))
                0: rel = 65537;
                1: rel = 32'h7FFFFFFF;
                2: rel = $urandom_range(70000, 600000);
                default: rel = ($urandom & 32'h7FFFFFFF) | 32'h20000;
            endcase
            set_search(lo, up, eps, rel, $urandom_range(9) == 0 ? 0 : $urandom_range(1, 12));
            obj_mode = $urandom_range(3);
            obj_center = (longint'(lo) + up) / 2 + int'($urandom_range(40000)) - 20000;
            send_word(REQ_START, 0);
            while (ph == PH_BOUNDS || ph == PH_RUN) begin
                if (hold_off && $urandom_range(5) == 0) drain();
                if ($urandom_range(29) == 0)
                    send_word(REQ_START, 0);
                else if ($urandom_range(19) == 0)
                    send_word(REQ_VALUE, $urandom);
                else
                    send_word(REQ_VALUE, probe_value(pend_pt));
            end
            if ($urandom_range(3) == 0) send_word(REQ_VALUE, $urandom);
        end
    endtask

    initial begin
        int waited;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(25, 0, 0);
        test_random(25, 47, 1);
        test_random(25, 10, 0);
        test_random(25, 47, 0);
        waited = 0;
        while (expected_words.size() != 0 && waited < 400000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        $display("Sent %0d request words over %0d searches; %0d result words checked.",
                 n_items, n_searches, n_words);
        $display("Searches ended by convergence: %0d, by trial limit: %0d.", n_conv, n_limit);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit well beyond the slowest correct run.
    initial begin
        #100ms;
        $display("Run limit reached with %0d words outstanding.", expected_words.size());
        $display("FAIL");
        $finish;
    end

endmodule
